// ===== sv/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, defaults and width helpers for the matrix to quaternion unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS_DEF  = 14;
  localparam int DATA_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    SEL_E4 = 2'd0,
    SEL_E1 = 2'd1,
    SEL_E2 = 2'd2,
    SEL_E3 = 2'd3
  } sel_t;

  typedef struct packed {
    logic valid;
    logic err;
    sel_t sel;
  } rmq_ctl_t;

  // trace sum width, signed
  function automatic int sum_w(input int dw, input int fb);
    return ((fb > dw) ? fb : dw) + 3;
  endfunction

  // root width
  function automatic int root_w(input int dw, input int fb);
    return (sum_w(dw, fb) - 1 + fb - 2 + 1) / 2;
  endfunction

  // radicand width, even
  function automatic int rad_w(input int dw, input int fb);
    return 2 * root_w(dw, fb);
  endfunction

  // off-diagonal numerator width, signed
  function automatic int num_w(input int dw);
    return dw + 1;
  endfunction

  // quotient magnitude width
  function automatic int quo_w(input int dw);
    return dw + 1;
  endfunction

endpackage

// ===== sv/rmq_in_if.sv =====
// ----------------------------------------------------------------------------
// rmq_in_if
// Matrix input channel: valid/ready with nine signed entries.
// ----------------------------------------------------------------------------
interface rmq_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] r00;
  logic signed [DATA_WIDTH-1:0] r01;
  logic signed [DATA_WIDTH-1:0] r02;
  logic signed [DATA_WIDTH-1:0] r10;
  logic signed [DATA_WIDTH-1:0] r11;
  logic signed [DATA_WIDTH-1:0] r12;
  logic signed [DATA_WIDTH-1:0] r20;
  logic signed [DATA_WIDTH-1:0] r21;
  logic signed [DATA_WIDTH-1:0] r22;

  modport source (
    output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
    input  ready
  );

  modport sink (
    input  valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
    output ready
  );
endinterface

// ===== sv/rmq_out_if.sv =====
// ----------------------------------------------------------------------------
// rmq_out_if
// Quaternion result channel: valid/ready with four components and flags.
// ----------------------------------------------------------------------------
interface rmq_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quat_w;
  logic signed [DATA_WIDTH-1:0] quat_x;
  logic signed [DATA_WIDTH-1:0] quat_y;
  logic signed [DATA_WIDTH-1:0] quat_z;
  logic        [1:0]            case_taken;
  logic                         not_rotation;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, case_taken, not_rotation,
    input  ready
  );

  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, case_taken, not_rotation,
    output ready
  );
endinterface

// ===== sv/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// Trace sums, case selection and off-diagonal numerators; one register stage.
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                                                     clk,
  input  logic                                                     rst_n,
  input  logic                                                     en,
  rmq_in_if.sink                                                   in_ch,
  output logic [rmq_pkg::rad_w(DATA_WIDTH, FRAC_BITS)-1:0]         rad_r,
  output logic [2:0][rmq_pkg::num_w(DATA_WIDTH)-1:0]               num_r,
  output rmq_pkg::rmq_ctl_t                                        ctl_r
);
  import rmq_pkg::*;

  localparam int EW   = sum_w(DATA_WIDTH, FRAC_BITS);
  localparam int RADW = rad_w(DATA_WIDTH, FRAC_BITS);
  localparam int NMW  = num_w(DATA_WIDTH);
  localparam logic signed [EW-1:0] ONE =
    {{(EW-1-FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic signed [EW-1:0]  d00, d11, d22;
  logic signed [EW-1:0]  e1, e2, e3, e4, e_pick;
  logic signed [NMW-1:0] a21m12, a02m20, a10m01, s10p01, s20p02, s21p12;
  logic [RADW-1:0]       rad_nxt;
  logic [2:0][NMW-1:0]   num_nxt;
  rmq_ctl_t              ctl_nxt;

  assign in_ch.ready = en;

  always_comb begin
    d00 = EW'(in_ch.r00);
    d11 = EW'(in_ch.r11);
    d22 = EW'(in_ch.r22);
    e4  = ONE + d00 + d11 + d22;
    e1  = ONE + d00 - d11 - d22;
    e2  = ONE - d00 + d11 - d22;
    e3  = ONE - d00 - d11 + d22;

    a21m12 = NMW'(in_ch.r21) - NMW'(in_ch.r12);
    a02m20 = NMW'(in_ch.r02) - NMW'(in_ch.r20);
    a10m01 = NMW'(in_ch.r10) - NMW'(in_ch.r01);
    s10p01 = NMW'(in_ch.r10) + NMW'(in_ch.r01);
    s20p02 = NMW'(in_ch.r20) + NMW'(in_ch.r02);
    s21p12 = NMW'(in_ch.r21) + NMW'(in_ch.r12);

    ctl_nxt.valid = in_ch.valid;
    ctl_nxt.err   = 1'b0;
    ctl_nxt.sel   = SEL_E4;
    e_pick        = e4;
    if (e4 >= ONE) begin
      ctl_nxt.sel = SEL_E4;
    end else if (e1 >= ONE) begin
      ctl_nxt.sel = SEL_E1;
      e_pick      = e1;
    end else if (e2 >= ONE) begin
      ctl_nxt.sel = SEL_E2;
      e_pick      = e2;
    end else if (e3 >= ONE) begin
      ctl_nxt.sel = SEL_E3;
      e_pick      = e3;
    end else begin
      ctl_nxt.err = 1'b1;
      e_pick      = ONE;
    end

    unique case (ctl_nxt.sel)
      SEL_E4: num_nxt = {a10m01, a02m20, a21m12};
      SEL_E1: num_nxt = {s20p02, s10p01, a21m12};
      SEL_E2: num_nxt = {s21p12, s10p01, a02m20};
      SEL_E3: num_nxt = {s21p12, s20p02, a10m01};
      default: num_nxt = '0;
    endcase
    if (ctl_nxt.err) begin
      num_nxt = '0;
    end

    rad_nxt = RADW'({e_pick[EW-2:0], {(FRAC_BITS-2){1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.err <= ctl_nxt.err;
      ctl_r.sel <= ctl_nxt.sel;
      rad_r     <= rad_nxt;
      num_r     <= num_nxt;
    end
  end

endmodule

// ===== sv/rmq_sqrt.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined restoring square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              en,
  input  logic [rmq_pkg::rad_w(DATA_WIDTH, FRAC_BITS)-1:0]  rad,
  input  logic [2:0][rmq_pkg::num_w(DATA_WIDTH)-1:0]        num,
  input  rmq_pkg::rmq_ctl_t                                 ctl,
  output logic [rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS)-1:0] root,
  output logic [2:0][rmq_pkg::num_w(DATA_WIDTH)-1:0]        num_out,
  output rmq_pkg::rmq_ctl_t                                 ctl_out
);
  import rmq_pkg::*;

  localparam int CW   = root_w(DATA_WIDTH, FRAC_BITS);
  localparam int RADW = rad_w(DATA_WIDTH, FRAC_BITS);
  localparam int RMW  = CW + 2;
  localparam int NMW  = num_w(DATA_WIDTH);

  logic     [CW-1:0][RADW-1:0]       rad_r;
  logic     [CW-1:0][RMW-1:0]        rem_r;
  logic     [CW-1:0][CW-1:0]         root_r;
  logic     [CW-1:0][2:0][NMW-1:0]   num_r;
  rmq_ctl_t [CW-1:0]                 ctl_r;

  for (genvar gi = 0; gi < CW; gi++) begin : g_stage
    logic [RADW-1:0]     rad_p;
    logic [RMW-1:0]      rem_p;
    logic [CW-1:0]       root_p;
    logic [2:0][NMW-1:0] num_p;
    rmq_ctl_t            ctl_p;
    logic [RMW+1:0]      tmp, trial, diff;
    logic                ge;
    logic [RADW-1:0]     rad_nxt;
    logic [RMW-1:0]      rem_nxt;
    logic [CW-1:0]       root_nxt;

    if (gi == 0) begin : g_head
      assign rad_p  = rad;
      assign rem_p  = '0;
      assign root_p = '0;
      assign num_p  = num;
      assign ctl_p  = ctl;
    end else begin : g_body
      assign rad_p  = rad_r[gi-1];
      assign rem_p  = rem_r[gi-1];
      assign root_p = root_r[gi-1];
      assign num_p  = num_r[gi-1];
      assign ctl_p  = ctl_r[gi-1];
    end

    always_comb begin
      tmp      = {rem_p, rad_p[RADW-1 -: 2]};
      trial    = {2'b00, root_p, 2'b01};
      diff     = tmp - trial;
      ge       = (tmp >= trial);
      rem_nxt  = ge ? diff[RMW-1:0] : tmp[RMW-1:0];
      root_nxt = {root_p[CW-2:0], ge};
      rad_nxt  = {rad_p[RADW-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[gi].valid <= 1'b0;
      end else if (en) begin
        ctl_r[gi].valid <= ctl_p.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[gi].err <= ctl_p.err;
        ctl_r[gi].sel <= ctl_p.sel;
        rad_r[gi]     <= rad_nxt;
        rem_r[gi]     <= rem_nxt;
        root_r[gi]    <= root_nxt;
        num_r[gi]     <= num_p;
      end
    end
  end

  assign root    = root_r[CW-1];
  assign num_out = num_r[CW-1];
  assign ctl_out = ctl_r[CW-1];

  a_sqrt_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[CW-1].valid |-> rem_r[CW-1] <= RMW'({root_r[CW-1], 1'b0}))
    else $error("square root remainder above twice the root");

endmodule

// ===== sv/rmq_div.sv =====
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider, one quotient bit per stage, with
// round-to-nearest bias folded into the dividend.
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              en,
  input  logic [rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS)-1:0] root,
  input  logic [2:0][rmq_pkg::num_w(DATA_WIDTH)-1:0]        num,
  input  rmq_pkg::rmq_ctl_t                                 ctl,
  output logic [rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS)-1:0] root_out,
  output logic [2:0][rmq_pkg::quo_w(DATA_WIDTH)-1:0]        quo,
  output logic [2:0]                                        neg,
  output rmq_pkg::rmq_ctl_t                                 ctl_out
);
  import rmq_pkg::*;

  localparam int CW  = root_w(DATA_WIDTH, FRAC_BITS);
  localparam int NMW = num_w(DATA_WIDTH);
  localparam int QW  = quo_w(DATA_WIDTH);
  localparam int DVW = CW + 2;
  localparam int NW  = DATA_WIDTH + FRAC_BITS + 2;

  logic     [QW-1:0][CW-1:0]          root_r;
  logic     [QW-1:0][2:0][DVW:0]      rem_r;
  logic     [QW-1:0][2:0][QW-1:0]     nlo_r;
  logic     [QW-1:0][2:0][QW-1:0]     quo_r;
  logic     [QW-1:0][2:0]             neg_r;
  rmq_ctl_t [QW-1:0]                  ctl_r;

  logic [2:0][DVW:0]  rem_in;
  logic [2:0][QW-1:0] nlo_in;
  logic [2:0]         neg_in;

  for (genvar gl = 0; gl < 3; gl++) begin : g_load
    logic [NMW-1:0] mag;
    logic [NW-1:0]  dividend, dshift;

    always_comb begin
      neg_in[gl]  = num[gl][NMW-1];
      mag         = neg_in[gl] ? NMW'(-num[gl]) : num[gl];
      dividend    = (NW'(mag) << FRAC_BITS) + NW'({root, 1'b0});
      dshift      = dividend >> QW;
      rem_in[gl]  = dshift[DVW:0];
      nlo_in[gl]  = dividend[QW-1:0];
    end
  end

  for (genvar gk = 0; gk < QW; gk++) begin : g_stage
    logic [CW-1:0]          root_p;
    logic [2:0][DVW:0]      rem_p;
    logic [2:0][QW-1:0]     nlo_p;
    logic [2:0][QW-1:0]     quo_p;
    logic [2:0]             neg_p;
    rmq_ctl_t               ctl_p;
    logic [DVW:0]           dvs;
    logic [2:0][DVW:0]      rem_nxt;
    logic [2:0][QW-1:0]     nlo_nxt;
    logic [2:0][QW-1:0]     quo_nxt;

    if (gk == 0) begin : g_head
      assign root_p = root;
      assign rem_p  = rem_in;
      assign nlo_p  = nlo_in;
      assign quo_p  = '0;
      assign neg_p  = neg_in;
      assign ctl_p  = ctl;
    end else begin : g_body
      assign root_p = root_r[gk-1];
      assign rem_p  = rem_r[gk-1];
      assign nlo_p  = nlo_r[gk-1];
      assign quo_p  = quo_r[gk-1];
      assign neg_p  = neg_r[gk-1];
      assign ctl_p  = ctl_r[gk-1];
    end

    assign dvs = {1'b0, root_p, 2'b00};

    for (genvar gl = 0; gl < 3; gl++) begin : g_lane
      logic [DVW:0] t;
      logic         ge;

      always_comb begin
        t              = {rem_p[gl][DVW-1:0], nlo_p[gl][QW-1]};
        ge             = (t >= dvs);
        rem_nxt[gl]    = ge ? (t - dvs) : t;
        quo_nxt[gl]    = {quo_p[gl][QW-2:0], ge};
        nlo_nxt[gl]    = {nlo_p[gl][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[gk].valid <= 1'b0;
      end else if (en) begin
        ctl_r[gk].valid <= ctl_p.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[gk].err <= ctl_p.err;
        ctl_r[gk].sel <= ctl_p.sel;
        root_r[gk]    <= root_p;
        rem_r[gk]     <= rem_nxt;
        nlo_r[gk]     <= nlo_nxt;
        quo_r[gk]     <= quo_nxt;
        neg_r[gk]     <= neg_p;
      end
    end
  end

  assign root_out = root_r[QW-1];
  assign quo      = quo_r[QW-1];
  assign neg      = neg_r[QW-1];
  assign ctl_out  = ctl_r[QW-1];

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[QW-1].valid |->
      (rem_r[QW-1][0] < {1'b0, root_r[QW-1], 2'b00}) &&
      (rem_r[QW-1][1] < {1'b0, root_r[QW-1], 2'b00}) &&
      (rem_r[QW-1][2] < {1'b0, root_r[QW-1], 2'b00}))
    else $error("divider remainder not below divisor");

endmodule

// ===== sv/rotation_matrix_to_quaternion_unit.sv =====
// Stages: front register, a square-root stage for each root bit (root_w), a
//   divider stage for each quotient bit (DATA_WIDTH + 1), output register;
//   15 root bits and 17 quotient bits at DATA_WIDTH 16, FRAC_BITS 14.
// Throughput: one matrix per cycle; a stalled output holds every stage in place.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Rotation matrix to unit quaternion by the first trace sum (e4, e1, e2, e3) to reach one.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rmq_in_if.sink    in_ch,
  rmq_out_if.source out_ch
);
  import rmq_pkg::*;

  localparam int CW   = root_w(DATA_WIDTH, FRAC_BITS);
  localparam int RADW = rad_w(DATA_WIDTH, FRAC_BITS);
  localparam int NMW  = num_w(DATA_WIDTH);
  localparam int QW   = quo_w(DATA_WIDTH);
  localparam int SW   = DATA_WIDTH + 2;
  localparam logic signed [SW-1:0] SAT_HI = {3'b000, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {3'b111, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] HI_U  = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic                 en;
  logic [RADW-1:0]      f_rad;
  logic [2:0][NMW-1:0]  f_num, s_num;
  rmq_ctl_t             f_ctl, s_ctl, d_ctl;
  logic [CW-1:0]        s_root, d_root;
  logic [2:0][QW-1:0]   d_quo;
  logic [2:0]           d_neg;

  logic                                out_valid_r;
  logic signed [DATA_WIDTH-1:0]        qw_r, qx_r, qy_r, qz_r;
  logic signed [DATA_WIDTH-1:0]        qw_nxt, qx_nxt, qy_nxt, qz_nxt;
  logic [1:0]                          case_r, case_nxt;
  logic                                err_r, err_nxt;
  logic [2:0][DATA_WIDTH-1:0]          lane_sat;
  logic [DATA_WIDTH-1:0]               half_sat;

  assign en = !out_valid_r || out_ch.ready;

  rmq_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_ch (in_ch),
    .rad_r (f_rad),
    .num_r (f_num),
    .ctl_r (f_ctl)
  );

  rmq_sqrt #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .rad     (f_rad),
    .num     (f_num),
    .ctl     (f_ctl),
    .root    (s_root),
    .num_out (s_num),
    .ctl_out (s_ctl)
  );

  rmq_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .root     (s_root),
    .num      (s_num),
    .ctl      (s_ctl),
    .root_out (d_root),
    .quo      (d_quo),
    .neg      (d_neg),
    .ctl_out  (d_ctl)
  );

  for (genvar gl = 0; gl < 3; gl++) begin : g_sat
    logic signed [SW-1:0] sval;

    always_comb begin
      sval = d_neg[gl] ? -$signed(SW'(d_quo[gl])) : $signed(SW'(d_quo[gl]));
      if (sval > SAT_HI) begin
        lane_sat[gl] = SAT_HI[DATA_WIDTH-1:0];
      end else if (sval < SAT_LO) begin
        lane_sat[gl] = SAT_LO[DATA_WIDTH-1:0];
      end else begin
        lane_sat[gl] = sval[DATA_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    if ((CW + DATA_WIDTH)'(d_root) > (CW + DATA_WIDTH)'(HI_U)) begin
      half_sat = HI_U;
    end else begin
      half_sat = DATA_WIDTH'(d_root);
    end

    unique case (d_ctl.sel)
      SEL_E4: begin
        qw_nxt = half_sat;    qx_nxt = lane_sat[0];
        qy_nxt = lane_sat[1]; qz_nxt = lane_sat[2];
      end
      SEL_E1: begin
        qw_nxt = lane_sat[0]; qx_nxt = half_sat;
        qy_nxt = lane_sat[1]; qz_nxt = lane_sat[2];
      end
      SEL_E2: begin
        qw_nxt = lane_sat[0]; qx_nxt = lane_sat[1];
        qy_nxt = half_sat;    qz_nxt = lane_sat[2];
      end
      SEL_E3: begin
        qw_nxt = lane_sat[0]; qx_nxt = lane_sat[1];
        qy_nxt = lane_sat[2]; qz_nxt = half_sat;
      end
      default: begin
        qw_nxt = '0; qx_nxt = '0; qy_nxt = '0; qz_nxt = '0;
      end
    endcase
    case_nxt = d_ctl.sel;
    err_nxt  = d_ctl.err;

    if (d_ctl.err) begin
      qw_nxt   = '0;
      qx_nxt   = '0;
      qy_nxt   = '0;
      qz_nxt   = '0;
      case_nxt = SEL_E4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qw_r   <= qw_nxt;
      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
      qz_r   <= qz_nxt;
      case_r <= case_nxt;
      err_r  <= err_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.quat_w       = qw_r;
  assign out_ch.quat_x       = qx_r;
  assign out_ch.quat_y       = qy_r;
  assign out_ch.quat_z       = qz_r;
  assign out_ch.case_taken   = case_r;
  assign out_ch.not_rotation = err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && err_r |->
      qw_r == '0 && qx_r == '0 && qy_r == '0 && qz_r == '0 && case_r == SEL_E4)
    else $error("error result carries non-zero data");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && !in_ch.ready || out_ch.ready)
    else $error("pending result dropped under stall");

endmodule

// ===== tb/rotation_matrix_to_quaternion_unit_checker.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit_checker
// Watches the matrix and quaternion channels, computes the expected quaternion
// for every matrix transfer and compares each result transfer in order.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit_checker (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  logic [143:0] in_flat,
  input  logic      out_valid,
  input  logic      out_ready,
  input  logic [15:0] out_w,
  input  logic [15:0] out_x,
  input  logic [15:0] out_y,
  input  logic [15:0] out_z,
  input  logic [1:0]  out_case,
  input  logic        out_err,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import rmq_pkg::*;

  localparam int FB = 14;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    sel_t        sel;
    logic        err;
  } quat_t;

  quat_t quat_q[$];

  function automatic longint isqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint rdiv(longint n, longint c);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = ((mag <<< FB) + 2 * c) / (4 * c);
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic [15:0] sat16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic quat_t shepperd_quat(logic [143:0] flat);
    longint m[9];
    longint e[4];
    longint q[4];
    longint one;
    longint c;
    int sel;
    quat_t res;
    one = 64'sd1 <<< FB;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(flat[16*i +: 16]));
    e[0] = one + m[0] + m[4] + m[8];
    e[1] = one + m[0] - m[4] - m[8];
    e[2] = one - m[0] + m[4] - m[8];
    e[3] = one - m[0] - m[4] + m[8];
    sel = -1;
    for (int i = 3; i >= 0; i--) if (e[i] >= one) sel = i;
    for (int i = 0; i < 4; i++) q[i] = 0;
    if (sel >= 0) begin
      c = isqrt(e[sel] <<< (FB - 2));
      case (sel)
        0: begin
          q[0] = c; q[1] = rdiv(m[7] - m[5], c);
          q[2] = rdiv(m[2] - m[6], c); q[3] = rdiv(m[3] - m[1], c);
        end
        1: begin
          q[0] = rdiv(m[7] - m[5], c); q[1] = c;
          q[2] = rdiv(m[3] + m[1], c); q[3] = rdiv(m[6] + m[2], c);
        end
        2: begin
          q[0] = rdiv(m[2] - m[6], c); q[1] = rdiv(m[1] + m[3], c);
          q[2] = c; q[3] = rdiv(m[5] + m[7], c);
        end
        default: begin
          q[0] = rdiv(m[3] - m[1], c); q[1] = rdiv(m[6] + m[2], c);
          q[2] = rdiv(m[7] + m[5], c); q[3] = c;
        end
      endcase
    end
    res.w = sat16(q[0]);
    res.x = sat16(q[1]);
    res.y = sat16(q[2]);
    res.z = sat16(q[3]);
    res.sel = (sel >= 0) ? sel_t'(sel) : SEL_E4;
    res.err = (sel < 0);
    return res;
  endfunction

  assign pending = quat_q.size();

  always @(posedge clk) begin
    quat_t exp_q;
    quat_t got;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) quat_q.push_back(shepperd_quat(in_flat));
      if (out_valid && out_ready) begin
        got = '{w: out_w, x: out_x, y: out_y, z: out_z, sel: sel_t'(out_case),
                err: out_err};
        if (quat_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer %p", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_q = quat_q.pop_front();
          if (got !== exp_q) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", exp_q, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/rotation_matrix_to_quaternion_unit_test.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit_test
// Drives directed and random matrices, rotations and raw patterns alike,
// with random idling on both sides; the checker judges every result.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 34;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   hold_n = 0;
  bit   calm = 1'b0;

  rmq_in_if  #(.DATA_WIDTH(16)) in_ch ();
  rmq_out_if #(.DATA_WIDTH(16)) out_ch ();

  rotation_matrix_to_quaternion_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  rotation_matrix_to_quaternion_unit_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_flat({in_ch.r22, in_ch.r21, in_ch.r20, in_ch.r12, in_ch.r11, in_ch.r10,
              in_ch.r02, in_ch.r01, in_ch.r00}),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_w(out_ch.quat_w), .out_x(out_ch.quat_x), .out_y(out_ch.quat_y),
    .out_z(out_ch.quat_z), .out_case(out_ch.case_taken),
    .out_err(out_ch.not_rotation),
    .fail_count(fail_count), .pending(pending)
  );

  always #6 clk = ~clk;

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] near(int v);
    return 16'(v + $signed($urandom_range(0, 64)) - 32);
  endfunction

  task automatic send(logic [143:0] m);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    {in_ch.r22, in_ch.r21, in_ch.r20, in_ch.r12, in_ch.r11, in_ch.r10,
     in_ch.r02, in_ch.r01, in_ch.r00} <= m;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [143:0] diag_mat(int a, int b, int c);
    return {16'(c), 48'd0, 16'(b), 48'd0, 16'(a)};
  endfunction

  // signed permutation-ish rotation with noise, picks which trace sum wins
  function automatic logic [143:0] rot_mat();
    int k;
    int s;
    logic [15:0] d[3];
    k = $urandom_range(0, 3);
    s = 16384;
    d[0] = (k == 0 || k == 1) ? near(s - 40) : near(-s + 40);
    d[1] = (k == 0 || k == 2) ? near(s - 40) : near(-s + 40);
    d[2] = (k == 0 || k == 3) ? near(s - 40) : near(-s + 40);
    return {d[2], near(0), near(0), near(0), d[1], near(0), near(0), near(0), d[0]};
  endfunction

  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_ch.ready <= 1'b1;
      hold_n       <= 0;
    end else if (hold_n > 0) begin
      out_ch.ready <= 1'b0;
      hold_n       <= hold_n - 1;
    end else if (out_ch.ready && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      hold_n       <= int'($urandom_range(0, 2));
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    logic [143:0] m;
    in_ch.valid = 1'b0;
    {in_ch.r22, in_ch.r21, in_ch.r20, in_ch.r12, in_ch.r11, in_ch.r10,
     in_ch.r02, in_ch.r01, in_ch.r00} = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send(diag_mat(16384, 16384, 16384));
    send(diag_mat(16384, -16384, -16384));
    send(diag_mat(-16384, 16384, -16384));
    send(diag_mat(-16384, -16384, 16384));
    send('0);
    send({9{16'h7fff}});
    send({9{16'h8000}});
    send({9{16'hffff}});
    send(diag_mat(32767, 32767, 32767));
    send(diag_mat(-32768, -32768, -32768));
    send(diag_mat(32767, -32768, -32768));
    send(diag_mat(-32768, 32767, -32768));
    send(diag_mat(-32768, -32768, 32767));
    send({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000, 16'h8000, 16'h7fff,
          16'h8000, 16'h0000});
    send({16'h0000, 16'h8000, 16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h8000,
          16'h7fff, 16'h0000});
    send(diag_mat(0, 0, 0));
    send({16'd0, 16'h7fff, 16'd0, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < 800; i++) begin
      if (i == 700) calm = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        m = rot_mat();
      end else begin
        for (int j = 0; j < 9; j++) m[16*j +: 16] = rnd16();
      end
      send(m);
    end
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0) $display("rotation_matrix_to_quaternion_unit_test: done, clean");
    else $display("rotation_matrix_to_quaternion_unit_test: done, errors");
    $finish;
  end

  initial begin
    #2ms;
    $display("rotation_matrix_to_quaternion_unit_test: done, errors");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/rmq_pkg.sv
sv/rmq_in_if.sv
sv/rmq_out_if.sv
sv/rmq_front.sv
sv/rmq_sqrt.sv
sv/rmq_div.sv
sv/rotation_matrix_to_quaternion_unit.sv
tb/rotation_matrix_to_quaternion_unit_checker.sv
tb/rotation_matrix_to_quaternion_unit_test.sv
